/* design/ols_pkg.sv */
// shared constants, types and helpers for the ordered list store
`timescale 1ns / 1ps
package ols_pkg;

	// store geometry
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// word field widths
	localparam int MODE_W  = 2;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int FIELD_W = 5;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              start;
		logic              insert;
		logic              step;
		logic              shift_wr;
		logic              latch_pos;
		logic              dec_count;
		logic              load_out;
		logic              use_pos;
		logic [STAT_W-1:0] out_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic scan_done;
		logic full;
		logic out_free;
	} sts_t;

	// fit a count or position into the result field, keeping the low bits
	function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] x);
		logic [CNT_W+FIELD_W-1:0] ext;
		ext = {{FIELD_W{1'b0}}, x};
		return ext[FIELD_W-1:0];
	endfunction

endpackage

/* design/ols_if.sv */
// request and response channel interfaces
`timescale 1ns / 1ps
interface ols_req_if;
	import ols_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic signed [VALUE_W-1:0]  value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

interface ols_rsp_if;
	import ols_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [FIELD_W-1:0] position;
	logic [FIELD_W-1:0] entry_count;

	modport source (output valid, output status, output position, output entry_count,
		input ready);
	modport sink (input valid, input status, input position, input entry_count,
		output ready);
endinterface

/* design/ols_ctrl.sv */
// controller state machine for the ordered list store
`timescale 1ns / 1ps
module ols_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [ols_pkg::MODE_W-1:0] req_mode,
	output logic                      req_ready,
	input  ols_pkg::sts_t             sts,
	output ols_pkg::cmd_t             cmd
);
	import ols_pkg::*;

	state_t            state_q, state_d;
	logic [MODE_W-1:0] mode_q, mode_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic              use_pos_q, use_pos_d;

	// state and per-word control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mode_q    <= MODE_INSERT;
			status_q  <= ST_OK;
			use_pos_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			mode_q    <= mode_d;
			status_q  <= status_d;
			use_pos_q <= use_pos_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		mode_d         = mode_q;
		status_d       = status_q;
		use_pos_d      = use_pos_q;
		req_ready      = 1'b0;
		cmd            = '0;
		cmd.out_status = status_q;
		cmd.use_pos    = use_pos_q;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					mode_d    = req_mode;
					status_d  = ST_OK;
					use_pos_d = 1'b0;
					case (req_mode)
						MODE_INSERT: state_d = S_INS;
						MODE_DELETE: state_d = S_SCAN;
						MODE_SEARCH: state_d = S_SCAN;
						default:     state_d = S_RESP;
					endcase
				end
			end
			S_INS: begin
				if (sts.full) begin
					status_d = ST_FULL;
				end else begin
					cmd.insert = 1'b1;
				end
				state_d = S_RESP;
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (sts.hit) begin
					cmd.latch_pos = 1'b1;
					use_pos_d     = 1'b1;
					state_d       = (mode_q == MODE_DELETE) ? S_SHIFT : S_RESP;
				end else if (sts.scan_done) begin
					status_d = ST_NOT_FOUND;
					state_d  = S_RESP;
				end
			end
			S_SHIFT: begin
				// the read pipeline keeps running, each entry moves down one slot
				cmd.step     = 1'b1;
				cmd.shift_wr = 1'b1;
				if (sts.scan_done) begin
					cmd.dec_count = 1'b1;
					state_d       = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* design/ols_dp.sv */
// datapath: entry memory, scan pipeline, count and output register
`timescale 1ns / 1ps
module ols_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [ols_pkg::VALUE_W-1:0] req_value,
	input  ols_pkg::cmd_t                    cmd,
	output ols_pkg::sts_t                    sts,
	input  logic                             rsp_ready,
	output logic                             rsp_valid,
	output logic [ols_pkg::STAT_W-1:0]       rsp_status,
	output logic [ols_pkg::FIELD_W-1:0]      rsp_position,
	output logic [ols_pkg::FIELD_W-1:0]      rsp_entry_count
);
	import ols_pkg::*;

	logic [VALUE_W-1:0] mem [DEPTH];

	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] rd_data_q;
	logic [IDX_W-1:0]   didx_q;
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   ptr_q;
	logic               rdv_q;
	logic               out_valid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [FIELD_W-1:0] out_pos_q;
	logic [FIELD_W-1:0] out_cnt_q;

	logic               issue;
	logic [IDX_W-1:0]   shift_addr;
	logic [CNT_W-1:0]   didx_ext;

	assign issue      = cmd.step && (ptr_q < count_q);
	assign shift_addr = didx_q - IDX_W'(1);
	assign didx_ext   = CNT_W'(didx_q);

	// status toward the controller
	assign sts.hit       = rdv_q && (rd_data_q == value_q);
	assign sts.scan_done = !rdv_q && (ptr_q >= count_q);
	assign sts.full      = (count_q == CNT_W'(DEPTH));
	assign sts.out_free  = !out_valid_q || rsp_ready;

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			mem[count_q[IDX_W-1:0]] <= value_q;
		end else if (cmd.shift_wr && rdv_q) begin
			mem[shift_addr] <= rd_data_q;
		end
		if (issue) begin
			rd_data_q <= mem[ptr_q[IDX_W-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			value_q <= req_value;
		end
		if (issue) begin
			didx_q <= ptr_q[IDX_W-1:0];
		end
		if (cmd.latch_pos) begin
			pos_q <= didx_ext + CNT_W'(1);
		end
		if (cmd.load_out) begin
			out_status_q <= cmd.out_status;
			out_pos_q    <= cmd.use_pos ? to_field(pos_q) : '0;
			out_cnt_q    <= to_field(count_q);
		end
	end

	// scan pointer, count and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			rdv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				ptr_q <= '0;
			end else if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			rdv_q <= issue;
			if (cmd.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp_status      = out_status_q;
	assign rsp_position    = out_pos_q;
	assign rsp_entry_count = out_cnt_q;

	// the count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	// an insert is only commanded into a store with room
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !sts.full)
		else $error("insert into full store");

	// a read in flight always refers to a held entry
	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_q |-> (didx_ext < count_q))
		else $error("read of an entry beyond the count");

	// a shift write never targets below slot zero
	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift_wr && rdv_q) |-> (didx_q != '0))
		else $error("shift write from slot zero");

	// a result is never loaded over one not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp_ready) |-> !cmd.load_out)
		else $error("result register overwritten");

endmodule

/* design/ordered_list_store_top.sv */
// Ordered list store: insert at end, delete first match, search first match.
// A search or delete scans the list from the head through the registered read port; a delete
// then moves each later entry down one slot. An unused mode code returns a plain result.
// One word at a time: the next word is accepted the cycle after the result is loaded,
// and a result is loaded only once the output register is free or its result is being taken.
// Asynchronous active-low reset empties the list; entries hold no reset value.
`timescale 1ns / 1ps
module ordered_list_store_top (
	input logic      clk,
	input logic      arst_n,
	ols_req_if.sink  req,
	ols_rsp_if.source rsp
);
	import ols_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	ols_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and compare
	ols_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_value       (req.value),
		.cmd             (cmd),
		.sts             (sts),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_status      (rsp.status),
		.rsp_position    (rsp.position),
		.rsp_entry_count (rsp.entry_count)
	);

endmodule

/* tb/ordered_list_store_top_tb.sv */
// self-checking testbench for the ordered list store, with a shadow list scoreboard
`timescale 1ns / 1ps
module ordered_list_store_top_tb;
	import ols_pkg::*;

	// mode 3 has no package name; the block treats it as a no-op
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_WORDS  = 950;
	localparam int MAX_GAP       = 11;
	localparam int STALL_LIMIT   = 4000;
	localparam int DRAIN_CYCLES  = 2 * DEPTH + 8;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [FIELD_W-1:0] position;
		logic [FIELD_W-1:0] entry_count;
	} list_result_t;

	// shadow copy of the list, expected results in acceptance order
	class list_shadow;
		logic [VALUE_W-1:0] shadow_entries [DEPTH];
		int                 shadow_count;
		list_result_t       pending_results [$];
		int                 errors;

		function new();
			shadow_count = 0;
			errors = 0;
		endfunction

		// apply one accepted request word to the shadow list
		function void note_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
			list_result_t res;
			int idx;
			idx = -1;
			res.status = ST_OK;
			res.position = '0;
			if (mode == MODE_DELETE || mode == MODE_SEARCH) begin
				for (int i = 0; i < shadow_count; i++) begin
					if (idx < 0 && shadow_entries[i] == value)
						idx = i;
				end
			end
			case (mode)
				MODE_INSERT: begin
					if (shadow_count >= DEPTH) begin
						res.status = ST_FULL;
					end else begin
						shadow_entries[shadow_count] = value;
						shadow_count++;
					end
				end
				MODE_DELETE: begin
					if (idx < 0) begin
						res.status = ST_NOT_FOUND;
					end else begin
						// close the gap, keeping order
						for (int i = idx; i + 1 < shadow_count; i++)
							shadow_entries[i] = shadow_entries[i + 1];
						shadow_count--;
						res.position = FIELD_W'(idx + 1);
					end
				end
				MODE_SEARCH: begin
					if (idx < 0)
						res.status = ST_NOT_FOUND;
					else
						res.position = FIELD_W'(idx + 1);
				end
				default: ;
			endcase
			res.entry_count = FIELD_W'(shadow_count);
			pending_results.push_back(res);
		endfunction

		// compare one accepted response word with the oldest expectation
		function void check_response(list_result_t got);
			list_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$error("response with nothing expected: status %0d position %0d count %0d",
					got.status, got.position, got.entry_count);
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				errors++;
				$error("status: expected %0d, actual %0d", want.status, got.status);
			end
			if (got.position !== want.position) begin
				errors++;
				$error("position: expected %0d, actual %0d", want.position, got.position);
			end
			if (got.entry_count !== want.entry_count) begin
				errors++;
				$error("entry_count: expected %0d, actual %0d", want.entry_count,
					got.entry_count);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ols_req_if req_ch ();
	ols_rsp_if rsp_ch ();

	ordered_list_store_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	list_shadow sb = new();

	// small pool of values so deletes and searches mostly hit
	logic [VALUE_W-1:0] value_pool [6];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog on cycles with no word moving on either channel
	int stall_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// drive one request word, with a random idle gap in front of it
	task automatic send_request(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value);
		int gap;
		gap = $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode  <= mode;
		req_ch.value <= value;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(mode, value);
	endtask

	// pick a value: mostly from the pool, sometimes fully random
	function automatic logic [VALUE_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 85)
			return value_pool[$urandom_range(0, 5)];
		return $urandom();
	endfunction

	// refresh the pool, sometimes with the signed extremes
	task automatic refresh_pool();
		for (int i = 0; i < 6; i++) begin
			case ($urandom_range(0, 7))
				0: value_pool[i] = 32'h8000_0000;
				1: value_pool[i] = 32'h7fff_ffff;
				2: value_pool[i] = 32'hffff_ffff;
				3: value_pool[i] = 32'h0000_0000;
				default: value_pool[i] = $urandom();
			endcase
		end
	endtask

	// response side: random stalls, check every accepted word
	initial begin
		list_result_t got;
		int gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = $urandom_range(0, MAX_GAP);
			// stretches without stalls
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got.status      = rsp_ch.status;
			got.position    = rsp_ch.position;
			got.entry_count = rsp_ch.entry_count;
			sb.check_response(got);
		end
	end

	// reset, directed words, random words, drain
	initial begin
		int pick;
		bit fill_phase;
		logic [MODE_W-1:0] mode;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode  = MODE_INSERT;
		req_ch.value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: misses and the no-op code
		send_request(MODE_SEARCH, 32'h0000_0000);
		send_request(MODE_DELETE, 32'h0000_0000);
		send_request(MODE_UNUSED, 32'hffff_ffff);
		// extremes and a duplicate
		send_request(MODE_INSERT, 32'h8000_0000);
		send_request(MODE_INSERT, 32'h7fff_ffff);
		send_request(MODE_INSERT, 32'hffff_ffff);
		send_request(MODE_INSERT, 32'h0000_0000);
		send_request(MODE_INSERT, 32'h7fff_ffff);
		// fill to the brim, then insert into a full list
		for (int i = 1; i <= DEPTH - 5; i++)
			send_request(MODE_INSERT, i);
		send_request(MODE_INSERT, 32'h5555_aaaa);
		// first match among duplicates, last slot, a miss
		send_request(MODE_SEARCH, 32'h7fff_ffff);
		send_request(MODE_SEARCH, DEPTH - 5);
		send_request(MODE_SEARCH, 32'h5555_aaaa);
		// delete at the head, the tail and the middle
		send_request(MODE_DELETE, 32'h8000_0000);
		send_request(MODE_DELETE, DEPTH - 5);
		send_request(MODE_DELETE, 32'h7fff_ffff);
		send_request(MODE_UNUSED, 32'h0000_0000);

		// random words, alternating fill-heavy and drain-heavy phases
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 100 == 0)
				refresh_pool();
			fill_phase = ((n / 60) % 2) == 0;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				mode = MODE_UNUSED;
			else if (pick < (fill_phase ? 65 : 25))
				mode = MODE_INSERT;
			else if (pick < (fill_phase ? 80 : 80))
				mode = MODE_DELETE;
			else
				mode = MODE_SEARCH;
			send_request(mode, pick_value());
		end
		req_ch.valid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
